FILE: rtl/perlin_noise_3d_macros.svh
// Assertion macros shared by the checker.
`ifndef PERLIN_NOISE_3D_MACROS_SVH
`define PERLIN_NOISE_3D_MACROS_SVH
`define PN_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define PN_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: rtl/pn3_pkg.sv
`default_nettype none
package pn3_pkg;
  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
    8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
    8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
    8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
    8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
    8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
    8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
    8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,
    8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
    8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,
    8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,
    8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,
    8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180};
  localparam logic [3:0] H_SPLIT_U = 4'd8;
  localparam logic [3:0] H_SPLIT_V = 4'd4;
  localparam logic [3:0] H_X_A = 4'd12;
  localparam logic [3:0] H_X_B = 4'd14;
endpackage
`default_nettype wire

FILE: rtl/pn3_pipe.sv
`default_nettype none
module pn3_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic stall,
  input  wire logic in_valid,
  input  wire logic [FRAC_BITS+7:0] cx,
  input  wire logic [FRAC_BITS+7:0] cy,
  input  wire logic [FRAC_BITS+7:0] cz,
  output logic out_valid,
  output logic signed [FRAC_BITS+2:0] result
);
  import pn3_pkg::*;
  localparam int F = FRAC_BITS;
  localparam int W = F + 5;
  localparam int S = 12;
  typedef logic signed [W-1:0] v_t;
  localparam v_t ONE = v_t'(1) <<< F;

  function automatic v_t mulfx(input v_t a, input v_t b);
    logic signed [2*W-1:0] p;
    begin
      p = a * b;
      mulfx = v_t'(p >>> F);
    end
  endfunction

  function automatic v_t grad(input logic [7:0] h, input v_t x, input v_t y, input v_t z);
    logic [3:0] h4;
    v_t u, v;
    begin
      h4 = h[3:0];
      u = (h4 < H_SPLIT_U) ? x : y;
      v = (h4 < H_SPLIT_V) ? y : ((h4 == H_X_A || h4 == H_X_B) ? x : z);
      grad = (h4[0] ? -u : u) + (h4[1] ? -v : v);
    end
  endfunction

  logic [S-1:0] vld;
  v_t fx [S], fy [S], fz [S];
  v_t ta [S][3], tb [S][3], tc [S][3], td [S][3];
  logic [7:0] ha [S], hb [S], aa [S], ab [S], ba [S], bb [S];
  logic [7:0] hsh [S][8];
  v_t g [S][8];
  v_t n [S][4];
  v_t m [S][2];
  v_t r [S];

  assign out_valid = vld[S-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (!stall) begin
      vld <= {vld[S-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      // Stage 0: split coordinates, first hash level, fade term a.
      fx[0] <= v_t'(cx[F-1:0]);
      fy[0] <= v_t'(cy[F-1:0]);
      fz[0] <= v_t'(cz[F-1:0]);
      ha[0] <= PERM[cx[F+7:F]] + cy[F+7:F];
      hb[0] <= PERM[8'(cx[F+7:F] + 8'd1)] + cy[F+7:F];
      aa[0] <= cz[F+7:F];
      ta[0][0] <= v_t'(6 * v_t'(cx[F-1:0]) - 15 * ONE);
      ta[0][1] <= v_t'(6 * v_t'(cy[F-1:0]) - 15 * ONE);
      ta[0][2] <= v_t'(6 * v_t'(cz[F-1:0]) - 15 * ONE);
      for (int i = 1; i < S; i++) begin
        fx[i] <= fx[i-1]; fy[i] <= fy[i-1]; fz[i] <= fz[i-1];
      end
      // Stage 1: second hash level, t*a and t*t.
      ab[1] <= PERM[ha[0]] + aa[0];
      bb[1] <= PERM[8'(ha[0] + 8'd1)] + aa[0];
      ba[1] <= PERM[hb[0]] + aa[0];
      hsh[1][0] <= PERM[8'(hb[0] + 8'd1)] + aa[0];
      tb[1][0] <= v_t'(mulfx(fx[0], ta[0][0]) + 10 * ONE);
      tb[1][1] <= v_t'(mulfx(fy[0], ta[0][1]) + 10 * ONE);
      tb[1][2] <= v_t'(mulfx(fz[0], ta[0][2]) + 10 * ONE);
      tc[1][0] <= mulfx(fx[0], fx[0]);
      tc[1][1] <= mulfx(fy[0], fy[0]);
      tc[1][2] <= mulfx(fz[0], fz[0]);
      // Stage 2: corner hashes, c*t.
      hsh[2][0] <= PERM[ab[1]];
      hsh[2][1] <= PERM[ba[1]];
      hsh[2][2] <= PERM[bb[1]];
      hsh[2][3] <= PERM[hsh[1][0]];
      hsh[2][4] <= PERM[8'(ab[1] + 8'd1)];
      hsh[2][5] <= PERM[8'(ba[1] + 8'd1)];
      hsh[2][6] <= PERM[8'(bb[1] + 8'd1)];
      hsh[2][7] <= PERM[8'(hsh[1][0] + 8'd1)];
      for (int k = 0; k < 3; k++) begin
        tb[2][k] <= tb[1][k];
        td[2][k] <= mulfx(tc[1][k], k == 0 ? fx[1] : (k == 1 ? fy[1] : fz[1]));
      end
      // Stage 3: gradients, fade result.
      g[3][0] <= grad(hsh[2][0], fx[2], fy[2], fz[2]);
      g[3][1] <= grad(hsh[2][1], fx[2] - ONE, fy[2], fz[2]);
      g[3][2] <= grad(hsh[2][2], fx[2], fy[2] - ONE, fz[2]);
      g[3][3] <= grad(hsh[2][3], fx[2] - ONE, fy[2] - ONE, fz[2]);
      g[3][4] <= grad(hsh[2][4], fx[2], fy[2], fz[2] - ONE);
      g[3][5] <= grad(hsh[2][5], fx[2] - ONE, fy[2], fz[2] - ONE);
      g[3][6] <= grad(hsh[2][6], fx[2], fy[2] - ONE, fz[2] - ONE);
      g[3][7] <= grad(hsh[2][7], fx[2] - ONE, fy[2] - ONE, fz[2] - ONE);
      for (int k = 0; k < 3; k++) tc[3][k] <= mulfx(td[2][k], tb[2][k]);
      // Stage 4: differences along x; stage 5: products; stage 6: sums.
      for (int j = 0; j < 4; j++) begin
        g[4][2*j] <= g[3][2*j];
        g[4][2*j+1] <= g[3][2*j+1] - g[3][2*j];
      end
      for (int k = 0; k < 3; k++) tc[4][k] <= tc[3][k];
      for (int j = 0; j < 4; j++) begin
        g[5][2*j] <= g[4][2*j];
        g[5][2*j+1] <= mulfx(tc[4][0], g[4][2*j+1]);
      end
      for (int k = 1; k < 3; k++) tc[5][k] <= tc[4][k];
      for (int j = 0; j < 4; j++) n[6][j] <= g[5][2*j] + g[5][2*j+1];
      for (int k = 1; k < 3; k++) tc[6][k] <= tc[5][k];
      // Stages 7 to 9: blend along y.
      n[7][0] <= n[6][0]; n[7][1] <= n[6][1] - n[6][0];
      n[7][2] <= n[6][2]; n[7][3] <= n[6][3] - n[6][2];
      tc[7][1] <= tc[6][1]; tc[7][2] <= tc[6][2];
      n[8][0] <= n[7][0]; n[8][1] <= mulfx(tc[7][1], n[7][1]);
      n[8][2] <= n[7][2]; n[8][3] <= mulfx(tc[7][1], n[7][3]);
      tc[8][2] <= tc[7][2];
      m[9][0] <= n[8][0] + n[8][1];
      m[9][1] <= n[8][2] + n[8][3];
      tc[9][2] <= tc[8][2];
      // Stages 10 and 11: blend along z.
      m[10][0] <= m[9][0];
      m[10][1] <= mulfx(tc[9][2], m[9][1] - m[9][0]);
      r[11] <= m[10][0] + m[10][1];
    end
  end

  always_comb begin
    if (r[S-1] > 2 * ONE) begin
      result = (FRAC_BITS+3)'(2 * ONE);
    end else if (r[S-1] < -2 * ONE) begin
      result = (FRAC_BITS+3)'(-2 * ONE);
    end else begin
      result = r[S-1][FRAC_BITS+2:0];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/perlin_noise_3d.sv
// A word passes through twelve pipeline stages and then one output register before its result
// word is offered.
// Throughput: one word per cycle unless the output stalls; the pipeline has twelve stages.
// An output stall freezes the pipeline while its last stage holds a word, and loses no word.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
`default_nettype none
module perlin_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [FRAC_BITS+7:0] coord_x,
  input  wire logic [FRAC_BITS+7:0] coord_y,
  input  wire logic [FRAC_BITS+7:0] coord_z,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [FRAC_BITS+2:0] noise_value
);
  logic stall;
  logic p_valid;
  logic signed [FRAC_BITS+2:0] p_res;

  assign stall = out_valid && !out_ready && p_valid;
  assign in_ready = !stall;

  pn3_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
    .clk(clk), .rst(rst), .stall(stall), .in_valid(in_valid && in_ready),
    .cx(coord_x), .cy(coord_y), .cz(coord_z),
    .out_valid(p_valid), .result(p_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      noise_value <= p_res;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pn3_checker.sv
`default_nettype none
`include "perlin_noise_3d_macros.svh"
module pn3_checker #(
  parameter int FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic signed [FRAC_BITS+2:0] noise_value
);
  `PN_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(noise_value))
  `PN_ASSERT_IMP(a_ready_free, clk, rst, out_ready, in_ready)
  `PN_ASSERT_IMP(a_range, clk, rst, out_valid,
    noise_value <= (2 <<< FRAC_BITS) && noise_value >= -(2 <<< FRAC_BITS))
endmodule
bind perlin_noise_3d pn3_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (.*);
`default_nettype wire
